// ----- hw/rtl/ppu_pkg.sv -----
package ppu_pkg;

    localparam int SLOT_W      = 6;
    localparam int POS_W       = 48;
    localparam int HALF_W      = 16;
    localparam int LIFE_W      = 15;
    localparam int COLOR_W     = 24;
    localparam int FADE_W      = 7;
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 120;

    localparam logic [FADE_W-1:0] FADE_FULL  = 7'd100;
    localparam logic              CMD_CREATE = 1'b0;
    localparam logic              CMD_TICK   = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_STATE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHR,
        CELL_SHL,
        CELL_WB
    } cell_op_t;

    // one particle as held in a cell
    typedef struct packed {
        logic        [SLOT_W-1:0]  slot;
        logic        [POS_W-1:0]   pos;
        logic        [POS_W-1:0]   vel;
        logic signed [HALF_W-1:0]  size;
        logic signed [HALF_W-1:0]  grow;
        logic signed [HALF_W-1:0]  life;
        logic        [LIFE_W-1:0]  life_start;
        logic        [HALF_W-1:0]  spin;
        logic signed [HALF_W-1:0]  srate;
        logic        [COLOR_W-1:0] color;
    } part_t;

    typedef struct packed {
        logic              dead;
        logic [FADE_W-1:0] fade;
        part_t             rec;
    } upd_res_t;

endpackage

// ----- hw/rtl/ppu_cell.sv -----
module ppu_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic             aclk,
    input  ppu_pkg::cell_op_t op,
    input  logic [CW-1:0]    wp,
    input  ppu_pkg::part_t   right_in,
    input  ppu_pkg::part_t   left_in,
    input  ppu_pkg::part_t   wb_in,
    output ppu_pkg::part_t   q
);
    import ppu_pkg::*;

    part_t q_reg;

    always_ff @(posedge aclk) begin
        unique case (op)
            CELL_SHR: q_reg <= right_in;
            CELL_SHL: q_reg <= left_in;
            CELL_WB: begin
                if (wp == CW'(IDX)) begin
                    q_reg <= wb_in;
                end
            end
            default: q_reg <= q_reg;
        endcase
    end

    assign q = q_reg;

endmodule

// ----- hw/rtl/ppu_update.sv -----
module ppu_update (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  ppu_pkg::part_t    rec,
    input  logic [14:0]       step,
    output logic              done,
    output ppu_pkg::upd_res_t res
);
    import ppu_pkg::*;

    localparam int DIV_STEPS = 7;
    localparam int REM_W     = 22;

    part_t                  rec_reg;
    logic signed [31:0]     prod_reg [5];
    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       dsr_reg;
    logic [FADE_W-1:0]      quo_reg;
    logic [3:0]             cnt_reg;
    logic                   done_reg;
    logic signed [16:0]     life_dec;
    logic signed [HALF_W:0] step_s;
    logic [REM_W:0]         trial;
    part_t                  rec_in;
    part_t                  rec_out;
    logic [FADE_W-1:0]      fade;

    // floor(prod / 256) added to base, clamped to 16 bits
    function automatic logic signed [15:0] add_sat(input logic signed [15:0] base,
                                                   input logic signed [31:0] prod);
        logic signed [23:0] inc;
        logic signed [24:0] sum;
        inc = prod[31:8];
        sum = {{9{base[15]}}, base} + {inc[23], inc};
        if (sum > 25'sd32767) begin
            add_sat = 16'sh7fff;
        end else if (sum < -25'sd32768) begin
            add_sat = 16'sh8000;
        end else begin
            add_sat = sum[15:0];
        end
    endfunction

    assign step_s   = {2'b00, step};
    assign life_dec = {rec.life[15], rec.life} - step_s;
    assign trial    = {1'b0, rem_reg} - {1'b0, dsr_reg};

    // incoming record with life already lowered by the step
    always_comb begin
        rec_in      = rec;
        rec_in.life = life_dec[15:0];
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rec_reg      <= rec_in;
            prod_reg[0]  <= $signed(rec.vel[15:0]) * step_s;
            prod_reg[1]  <= $signed(rec.vel[31:16]) * step_s;
            prod_reg[2]  <= $signed(rec.vel[47:32]) * step_s;
            prod_reg[3]  <= rec.grow * step_s;
            prod_reg[4]  <= rec.srate * step_s;
        end else if (cnt_reg == 4'(DIV_STEPS + 1)) begin
            rem_reg <= REM_W'(rec_reg.life[14:0]) * REM_W'(FADE_FULL);
            dsr_reg <= {1'b0, rec_reg.life_start, 6'b0};
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            if (!trial[REM_W]) begin
                rem_reg <= trial[REM_W-1:0];
                quo_reg <= {quo_reg[FADE_W-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[FADE_W-2:0], 1'b0};
            end
            dsr_reg <= dsr_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == 4'd1);
            if (start) begin
                cnt_reg <= 4'(DIV_STEPS + 1);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    always_comb begin
        rec_out               = rec_reg;
        rec_out.pos[15:0]     = add_sat($signed(rec_reg.pos[15:0]), prod_reg[0]);
        rec_out.pos[31:16]    = add_sat($signed(rec_reg.pos[31:16]), prod_reg[1]);
        rec_out.pos[47:32]    = add_sat($signed(rec_reg.pos[47:32]), prod_reg[2]);
        rec_out.size          = add_sat(rec_reg.size, prod_reg[3]);
        rec_out.spin          = rec_reg.spin + prod_reg[4][23:8];
        if (rec_reg.life_start == '0) begin
            fade = FADE_FULL;
        end else if (quo_reg > FADE_FULL) begin
            fade = FADE_FULL;
        end else begin
            fade = quo_reg;
        end
    end

    assign done     = done_reg;
    assign res.dead = rec_reg.life[15];
    assign res.fade = fade;
    assign res.rec  = rec_out;

endmodule

// ----- hw/rtl/particle_pool_update_top.sv -----
// particle pool: a fixed set of POOL_SLOTS particles kept in a row of cells
// s_ channel takes one word per command; s_tuser[0] is the command (0 create, 1 tick)
// s_tdata from bit 0: position, velocity, start_size, grow_rate, life_or_step,
//   spin_start, spin_rate, color, one zero pad bit
// m_ channel gives result words; m_tuser is the kind (accepted, full, particle state),
//   m_tlast marks the final word of a command
// create: one result word, put in the output register once that register is free
// tick: walks the cells from newest to oldest, one particle at a time; each particle
//   is popped from the head cell, passes through the shared update unit with a
//   7-step fade divider, and is written back if it survives
// survivors are written back behind the unvisited cells, so the row stays in order
// a tick with no survivor gives no word at all
// one finished word waits in the output register while the next command is taken;
// a stalled receiver holds the walk only when a second survivor word is ready
// reset (aresetn low, synchronous) empties the pool and refills the free stack
// with slots 0 up to POOL_SLOTS-1; no clearing pass is needed
module particle_pool_update_top #(
    parameter int POOL_SLOTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // position, velocity, start_size, grow_rate, life_or_step, spin_start, spin_rate,
    // color, pad
    input  logic [199:0] s_tdata,
    // command
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot, position_res, size, spin, fade_percent, color_res, pad
    output logic [119:0] m_tdata,
    // kind
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    import ppu_pkg::*;

    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(POOL_SLOTS);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CREATE = 6'b000010,
        ST_POP    = 6'b000100,
        ST_CALC   = 6'b001000,
        ST_SURV   = 6'b010000,
        ST_FLUSH  = 6'b100000
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [POS_W-1:0]    pos;
        logic [HALF_W-1:0]   size;
        logic [HALF_W-1:0]   spin;
        logic [FADE_W-1:0]   fade;
        logic [COLOR_W-1:0]  color;
    } res_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     used_cnt_reg, used_cnt_next;
    logic [CW-1:0]     free_cnt_reg, free_cnt_next;
    logic [CW-1:0]     qn_reg, qn_next;   // unvisited cells at the head of the row
    logic [CW-1:0]     sv_reg, sv_next;   // survivors already written back
    logic [IN_TDATA_W-1:0] in_reg, in_next;
    logic [SLOT_W-1:0] stack_reg [POOL_SLOTS];
    res_t              pend_reg, pend_next;
    logic              pend_vld_reg, pend_vld_next;
    res_t              out_reg, out_next;
    logic              out_last_reg, out_last_next;
    logic              out_vld_reg, out_vld_next;

    logic              out_free;
    logic              stk_pop, stk_push;
    cell_op_t          cell_op;
    logic [CW-1:0]     wp;
    part_t             new_rec;
    part_t             cell_q [POOL_SLOTS];
    logic              upd_start;
    logic              upd_done;
    upd_res_t          upd_res;
    res_t              surv_res;

    assign out_free = !out_vld_reg || m_tready;
    assign wp       = qn_reg + sv_reg;

    // record built from the latched create word
    always_comb begin
        new_rec.slot       = stack_reg[0];
        new_rec.pos        = in_reg[47:0];
        new_rec.vel        = in_reg[95:48];
        new_rec.size       = in_reg[111:96];
        new_rec.grow       = in_reg[127:112];
        new_rec.life       = {1'b0, in_reg[142:128]};
        new_rec.life_start = in_reg[142:128];
        new_rec.spin       = in_reg[158:143];
        new_rec.srate      = in_reg[174:159];
        new_rec.color      = in_reg[198:175];
    end

    always_comb begin
        surv_res.kind  = KIND_STATE;
        surv_res.slot  = upd_res.rec.slot;
        surv_res.pos   = upd_res.rec.pos;
        surv_res.size  = upd_res.rec.size;
        surv_res.spin  = upd_res.rec.spin;
        surv_res.fade  = upd_res.fade;
        surv_res.color = upd_res.rec.color;
    end

    // row of particle cells, head at index 0
    for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
        part_t right_in, left_in;
        if (i == 0) begin : g_head
            assign right_in = new_rec;
        end else begin : g_mid
            assign right_in = cell_q[i-1];
        end
        if (i == POOL_SLOTS - 1) begin : g_tail
            assign left_in = '0;
        end else begin : g_body
            assign left_in = cell_q[i+1];
        end
        ppu_cell #(.IDX(i), .CW(CW)) u_cell (
            .aclk     (aclk),
            .op       (cell_op),
            .wp       (wp),
            .right_in (right_in),
            .left_in  (left_in),
            .wb_in    (upd_res.rec),
            .q        (cell_q[i])
        );
    end

    ppu_update u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (upd_start),
        .rec     (cell_q[0]),
        .step    (in_reg[142:128]),
        .done    (upd_done),
        .res     (upd_res)
    );

    always_comb begin
        state_next    = state_reg;
        used_cnt_next = used_cnt_reg;
        free_cnt_next = free_cnt_reg;
        qn_next       = qn_reg;
        sv_next       = sv_reg;
        in_next       = in_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        s_tready      = 1'b0;
        stk_pop       = 1'b0;
        stk_push      = 1'b0;
        cell_op       = CELL_HOLD;
        upd_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    in_next = s_tdata;
                    if (s_tuser[0] == CMD_CREATE) begin
                        state_next = ST_CREATE;
                    end else begin
                        qn_next = used_cnt_reg;
                        sv_next = '0;
                        if (used_cnt_reg != '0) begin
                            state_next = ST_POP;
                        end
                    end
                end
            end
            ST_CREATE: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (free_cnt_reg == '0) begin
                        out_next      = '0;
                        out_next.kind = KIND_FULL;
                    end else begin
                        out_next.kind  = KIND_ACCEPT;
                        out_next.slot  = new_rec.slot;
                        out_next.pos   = new_rec.pos;
                        out_next.size  = new_rec.size;
                        out_next.spin  = new_rec.spin;
                        out_next.fade  = FADE_FULL;
                        out_next.color = new_rec.color;
                        cell_op        = CELL_SHR;
                        stk_pop        = 1'b1;
                        free_cnt_next  = free_cnt_reg - ONE_C;
                        used_cnt_next  = used_cnt_reg + ONE_C;
                    end
                end
            end
            ST_POP: begin
                upd_start  = 1'b1;
                cell_op    = CELL_SHL;
                qn_next    = qn_reg - ONE_C;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (upd_done) begin
                    state_next = ST_SURV;
                end
            end
            ST_SURV: begin
                if (upd_res.dead) begin
                    stk_push      = 1'b1;
                    free_cnt_next = free_cnt_reg + ONE_C;
                    used_cnt_next = used_cnt_reg - ONE_C;
                    state_next    = (qn_reg == '0) ? ST_FLUSH : ST_POP;
                end else if (!pend_vld_reg || out_free) begin
                    cell_op = CELL_WB;
                    sv_next = sv_reg + ONE_C;
                    if (pend_vld_reg) begin
                        out_next      = pend_reg;
                        out_last_next = 1'b0;
                        out_vld_next  = 1'b1;
                    end
                    pend_next     = surv_res;
                    pend_vld_next = 1'b1;
                    state_next    = (qn_reg == '0) ? ST_FLUSH : ST_POP;
                end
            end
            ST_FLUSH: begin
                if (!pend_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next      = pend_reg;
                    out_last_next = 1'b1;
                    out_vld_next  = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_cnt_reg <= '0;
            free_cnt_reg <= SLOTS_C;
            qn_reg       <= '0;
            sv_reg       <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int i = 0; i < POOL_SLOTS; i++) begin
                stack_reg[i] <= SLOT_W'(i);
            end
        end else begin
            state_reg    <= state_next;
            used_cnt_reg <= used_cnt_next;
            free_cnt_reg <= free_cnt_next;
            qn_reg       <= qn_next;
            sv_reg       <= sv_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            // free stack, top at index 0
            if (stk_pop) begin
                for (int i = 0; i < POOL_SLOTS - 1; i++) begin
                    stack_reg[i] <= stack_reg[i+1];
                end
            end else if (stk_push) begin
                stack_reg[0] <= upd_res.rec.slot;
                for (int i = 1; i < POOL_SLOTS; i++) begin
                    stack_reg[i] <= stack_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_reg.color, out_reg.fade, out_reg.spin, out_reg.size,
                       out_reg.pos, out_reg.slot};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_slot_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_cnt_reg + free_cnt_reg) == SLOTS_C)
        else $error("used and free slot counts do not add up to the pool size");

    a_pend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_vld_reg)
        else $error("held survivor word left behind after a tick");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> (qn_reg != '0))
        else $error("pop from an empty walk queue");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_CREATE) |-> (wp <= used_cnt_reg))
        else $error("walk pointers run past the live particle count");

    a_fade_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[92:86] <= FADE_FULL))
        else $error("fade percent above 100");
`endif

endmodule
